FILE: design/thread_status_delay_tick_unit_assert.svh
// Assertion macros for the thread status delay tick unit.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef THREAD_STATUS_DELAY_TICK_UNIT_ASSERT_SVH
`define THREAD_STATUS_DELAY_TICK_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define TSDT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsdt assertion failed");

// Next-cycle implication, disabled during reset.
`define TSDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsdt assertion failed");

`else

`define TSDT_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TSDT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/tsdt_pkg.sv
// Shared types and constants for the thread status delay tick unit.
// No dependencies.
package tsdt_pkg;

  localparam int OPCODE_W   = 3;
  localparam int INDEX_W    = 3;
  localparam int TICKS_IN_W = 16;
  localparam int MASK_W     = 8;
  localparam int TICK_W     = 32;

  localparam logic [MASK_W-1:0] DISABLED_RESET = 8'hfe;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK    = 3'd0,
    OP_ENABLE  = 3'd1,
    OP_DISABLE = 3'd2,
    OP_SUSPEND = 3'd3,
    OP_RESUME  = 3'd4,
    OP_DELAY   = 3'd5
  } opcode_t;

  typedef struct packed {
    logic [OPCODE_W-1:0]   opcode;
    logic [INDEX_W-1:0]    thread_index;
    logic [TICKS_IN_W-1:0] delay_ticks;
  } tsdt_cmd_t;

  typedef struct packed {
    logic [MASK_W-1:0] ready_mask;
    logic [MASK_W-1:0] delayed_mask;
    logic [TICK_W-1:0] tick_count;
  } tsdt_result_t;

endpackage

FILE: design/thread_status_delay_tick_unit.sv
// Thread status unit: one command or tick per transaction, one result per transaction.
// Path: accepted input -> input register -> result register, which drives out_valid.
// Throughput: one transaction per cycle while out_ready is high; the state update is combinational.
// Reset (rst_n low, synchronous): threads 1 and up disabled, other core state and valid flags cleared.
// Depends on tsdt_pkg, tsdt_in_stage, tsdt_core and tsdt_out_stage.
module thread_status_delay_tick_unit #(
  parameter int THREAD_COUNT = 8,
  parameter int DELAY_BITS   = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tsdt_pkg::OPCODE_W-1:0]   in_opcode,
  input  logic [tsdt_pkg::INDEX_W-1:0]    in_thread_index,
  input  logic [tsdt_pkg::TICKS_IN_W-1:0] in_delay_ticks,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tsdt_pkg::MASK_W-1:0]     out_ready_mask,
  output logic [tsdt_pkg::MASK_W-1:0]     out_delayed_mask,
  output logic [tsdt_pkg::TICK_W-1:0]     out_tick_count
);
  import tsdt_pkg::*;

  tsdt_cmd_t    in_cmd;
  tsdt_cmd_t    cmd;
  logic         cmd_vld;
  logic         advance;
  tsdt_result_t result;
  tsdt_result_t out_result;

  assign in_cmd.opcode       = in_opcode;
  assign in_cmd.thread_index = in_thread_index;
  assign in_cmd.delay_ticks  = in_delay_ticks;

  assign advance = cmd_vld && (!out_valid || out_ready);

  tsdt_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .advance  (advance),
    .cmd_vld  (cmd_vld),
    .cmd      (cmd)
  );

  tsdt_core #(
    .THREAD_COUNT (THREAD_COUNT),
    .DELAY_BITS   (DELAY_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .cmd     (cmd),
    .result  (result)
  );

  tsdt_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .result     (result),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  assign out_ready_mask   = out_result.ready_mask;
  assign out_delayed_mask = out_result.delayed_mask;
  assign out_tick_count   = out_result.tick_count;

endmodule

FILE: design/tsdt_in_stage.sv
// Input register of the thread status delay tick unit.
// Depends on tsdt_pkg.
module tsdt_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tsdt_pkg::tsdt_cmd_t in_cmd,
  input  logic               advance,
  output logic               cmd_vld,
  output tsdt_pkg::tsdt_cmd_t cmd
);
  import tsdt_pkg::*;

  logic      vld_r, vld_nxt;
  tsdt_cmd_t cmd_r, cmd_nxt;
  logic      take;

  assign in_ready = !vld_r || advance;
  assign take     = in_valid && in_ready;

  always_comb begin
    vld_nxt = vld_r;
    cmd_nxt = cmd_r;
    if (take) begin
      vld_nxt = 1'b1;
      cmd_nxt = in_cmd;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    cmd_r <= cmd_nxt;
  end

  assign cmd_vld = vld_r;
  assign cmd     = cmd_r;

endmodule

FILE: design/tsdt_core.sv
// Thread masks, delay counters and tick counter with their next-state update logic.
// Depends on tsdt_pkg and thread_status_delay_tick_unit_assert.svh.
`include "thread_status_delay_tick_unit_assert.svh"

module tsdt_core #(
  parameter int THREAD_COUNT = 8,
  parameter int DELAY_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  tsdt_pkg::tsdt_cmd_t   cmd,
  output tsdt_pkg::tsdt_result_t result
);
  import tsdt_pkg::*;

  localparam int IDX_CMP_W = INDEX_W + 1;

  logic [THREAD_COUNT-1:0] disabled_r, disabled_nxt;
  logic [THREAD_COUNT-1:0] suspended_r, suspended_nxt;
  logic [THREAD_COUNT-1:0] delayed_r, delayed_nxt;
  logic [DELAY_BITS-1:0]   cnt_r [THREAD_COUNT];
  logic [DELAY_BITS-1:0]   cnt_nxt [THREAD_COUNT];
  logic [TICK_W-1:0]       ticks_r, ticks_nxt;
  logic                    idx_ok;
  logic [THREAD_COUNT-1:0] sel;
  logic [THREAD_COUNT-1:0] ready_bits;

  always_comb begin
    disabled_nxt  = disabled_r;
    suspended_nxt = suspended_r;
    delayed_nxt   = delayed_r;
    cnt_nxt       = cnt_r;
    ticks_nxt     = ticks_r;
    idx_ok = {1'b0, cmd.thread_index} < IDX_CMP_W'(THREAD_COUNT);
    if (cmd.opcode == OP_TICK) begin
      ticks_nxt = ticks_r + TICK_W'(1);
    end
    for (int t = 0; t < THREAD_COUNT; t++) begin
      sel[t] = idx_ok && (cmd.thread_index == INDEX_W'(t));
      case (cmd.opcode)
        OP_TICK: begin
          cnt_nxt[t] = cnt_r[t] - DELAY_BITS'(1);
          if (cnt_nxt[t] == '0) begin
            delayed_nxt[t] = 1'b0;
          end
        end
        OP_ENABLE: begin
          if (sel[t]) disabled_nxt[t] = 1'b0;
        end
        OP_DISABLE: begin
          if (sel[t]) disabled_nxt[t] = 1'b1;
        end
        OP_SUSPEND: begin
          if (sel[t]) suspended_nxt[t] = 1'b1;
        end
        OP_RESUME: begin
          if (sel[t]) suspended_nxt[t] = 1'b0;
        end
        OP_DELAY: begin
          if (sel[t]) begin
            cnt_nxt[t]     = DELAY_BITS'(cmd.delay_ticks);
            delayed_nxt[t] = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disabled_r  <= DISABLED_RESET[THREAD_COUNT-1:0];
      suspended_r <= '0;
      delayed_r   <= '0;
      ticks_r     <= '0;
      for (int t = 0; t < THREAD_COUNT; t++) begin
        cnt_r[t] <= '0;
      end
    end else if (advance) begin
      disabled_r  <= disabled_nxt;
      suspended_r <= suspended_nxt;
      delayed_r   <= delayed_nxt;
      ticks_r     <= ticks_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  assign ready_bits          = ~(disabled_nxt | suspended_nxt | delayed_nxt);
  assign result.ready_mask   = MASK_W'(ready_bits);
  assign result.delayed_mask = MASK_W'(delayed_nxt);
  assign result.tick_count   = ticks_nxt;

  `TSDT_ASSERT_NEXT(a_tick_incr, clk, rst_n, advance && (cmd.opcode == OP_TICK),
                    ticks_r == $past(ticks_r) + TICK_W'(1))
  `TSDT_ASSERT_NEXT(a_hold_idle, clk, rst_n, !advance,
                    $stable(ticks_r) && $stable(delayed_r) && $stable(disabled_r))
  `TSDT_ASSERT_NEXT(a_cmd_no_tick, clk, rst_n, advance && (cmd.opcode != OP_TICK),
                    $stable(ticks_r))

endmodule

FILE: design/tsdt_out_stage.sv
// Result register of the thread status delay tick unit.
// Depends on tsdt_pkg and thread_status_delay_tick_unit_assert.svh.
`include "thread_status_delay_tick_unit_assert.svh"

module tsdt_out_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   advance,
  input  tsdt_pkg::tsdt_result_t result,
  output logic                   out_valid,
  input  logic                   out_ready,
  output tsdt_pkg::tsdt_result_t out_result
);
  import tsdt_pkg::*;

  logic         vld_r, vld_nxt;
  tsdt_result_t res_r, res_nxt;

  always_comb begin
    vld_nxt = vld_r;
    res_nxt = res_r;
    if (advance) begin
      vld_nxt = 1'b1;
      res_nxt = result;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_valid  = vld_r;
  assign out_result = res_r;

  `TSDT_ASSERT_NEXT(a_load_valid, clk, rst_n, advance, vld_r)
  `TSDT_ASSERT_IMPLY(a_no_overwrite, clk, rst_n, vld_r && !out_ready, !advance)
  `TSDT_ASSERT_NEXT(a_hold_result, clk, rst_n, vld_r && !out_ready, vld_r && $stable(res_r))

endmodule
